// ===== rtl/i2c_master_transaction_unit_assert.svh =====
// Assertion macros shared by the I2C master transaction unit.
// Depends on nothing; included by the top level, which checks its own logic.
`ifndef I2C_MASTER_TRANSACTION_UNIT_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_UNIT_ASSERT_SVH

// Whenever the condition holds, the consequence must hold in the same cycle.
`define I2CM_ASSERT_SAME(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("i2cm check failed in the same cycle");

// Whenever the condition holds, the consequence must hold in the following cycle.
`define I2CM_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("i2cm check failed one cycle later");

`endif

// ===== rtl/i2cm_pkg.sv =====
// Package for the I2C master transaction unit: widths, codes and payload types.
// Depends on nothing; imported by the interfaces, the result register, the core and the top level.
`timescale 1ns / 1ps

package i2cm_pkg;

  // Send store geometry.
  localparam int SEND_DEPTH = 256;
  localparam int STORE_AW   = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
  localparam int FILL_W     = $clog2(SEND_DEPTH + 1);

  // Timing register.
  localparam int          HALF_W     = 16;
  localparam logic [15:0] HALF_RESET = 16'd5;

  // Item actions.
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2
  } action_t;

  // Request status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_BUSY  = 2'd1,
    STAT_COUNT = 2'd2
  } status_t;

  // Bus sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_SETUP    = 4'd3,
    PH_HIGH     = 4'd4,
    PH_LOW      = 4'd5,
    PH_RSTART_A = 4'd6,
    PH_RSTART_B = 4'd7,
    PH_STOP_A   = 4'd8,
    PH_STOP_B   = 4'd9
  } phase_t;

  // Which kind of byte is on the bus.
  typedef enum logic [1:0] {
    STG_ADDR_W   = 2'd0,
    STG_DATA_OUT = 2'd1,
    STG_ADDR_R   = 2'd2,
    STG_DATA_IN  = 2'd3
  } stage_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  send_byte;
    logic [6:0]  target_address;
    logic [8:0]  write_count;
    logic [15:0] read_count;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_final;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_item_t;

  // Write and read request toward the send store.
  typedef struct packed {
    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic [STORE_AW-1:0] rd_addr;
  } store_req_t;

endpackage

// ===== rtl/i2cm_if.sv =====
// Valid/ready channel interfaces for command items and result items.
// Depends on i2cm_pkg for the payload types.
`timescale 1ns / 1ps

interface i2cm_in_if;
  import i2cm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface i2cm_out_if;
  import i2cm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== rtl/i2cm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the send store.
`timescale 1ns / 1ps

module i2cm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/i2cm_rsp_reg.sv =====
// Result register between the sequencer and the result channel.
// Depends on i2cm_pkg for the result type.
`timescale 1ns / 1ps

module i2cm_rsp_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  i2cm_pkg::out_item_t item_in,
  input  logic                take,
  output logic                valid,
  output i2cm_pkg::out_item_t item,
  output logic                space
);
  import i2cm_pkg::*;

  logic valid_next;

  // A new result may enter when the slot is empty or being emptied now.
  assign space = !valid || take;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload is only captured on a transfer into the slot.
  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

// ===== rtl/i2cm_core.sv =====
// Bus sequencer: store bookkeeping, half-period timer, phase machine and shifter.
// Depends on i2cm_pkg; reads the send store through a registered RAM port.
`timescale 1ns / 1ps

module i2cm_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  i2cm_pkg::in_item_t   item,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic [7:0]           store_rdata,
  output i2cm_pkg::store_req_t store_req,
  output i2cm_pkg::out_item_t  result
);
  import i2cm_pkg::*;

  // Data line drive for the setup half of a bit: data bits, then the ACK slot.
  function automatic logic setup_sda(input logic [3:0] bit_idx, input stage_t stg,
                                     input logic [7:0] shf, input logic [15:0] btr);
    logic drive;
    if (bit_idx < 4'd8) begin
      drive = (stg == STG_DATA_IN) ? 1'b0 : !shf[7];
    end else begin
      drive = (stg == STG_DATA_IN) ? (btr > 16'd1) : 1'b0;
    end
    return drive;
  endfunction

  logic [HALF_W-1:0] half_period;
  phase_t            phase, phase_next;
  stage_t            stage, stage_next;
  logic [3:0]        bit_index, bit_index_next;
  logic [HALF_W-1:0] half_timer, half_timer_next;
  logic [7:0]        shift_reg, shift_reg_next;
  logic [FILL_W-1:0] store_fill, store_fill_next;
  logic [FILL_W-1:0] store_read_ptr, store_read_ptr_next;
  logic [8:0]        bytes_to_send, bytes_to_send_next;
  logic [15:0]       bytes_to_read, bytes_to_read_next;
  logic [6:0]        address_reg, address_reg_next;
  logic              scl_low_reg, scl_low_reg_next;
  logic              sda_low_reg, sda_low_reg_next;

  logic              is_load, is_start, is_tick, is_idle;
  logic              load_ok, start_ok, tick_go, expire;
  logic [HALF_W-1:0] half_eff, timer_inc;
  logic [3:0]        bit_inc;
  logic [7:0]        shift_after;
  logic [15:0]       read_dec;
  logic              is_write_stage, more_send;
  logic              low_same, low_send, low_rstart, low_read, low_stop;
  logic              rx_valid, rx_final, done;
  logic [7:0]        rx_data;
  logic [1:0]        status;

  // Request decode.
  assign is_idle   = (phase == PH_IDLE);
  assign is_load   = accept && (item.action == ACT_LOAD);
  assign is_start  = accept && (item.action == ACT_START);
  assign is_tick   = accept && (item.action == ACT_TICK);
  assign load_ok   = is_load && is_idle && (store_fill < FILL_W'(SEND_DEPTH));
  assign start_ok  = is_start && is_idle && (item.write_count <= store_fill);

  // Half-period timer; a zero setting behaves as one tick.
  assign half_eff  = (half_period == '0) ? HALF_W'(1) : half_period;
  assign timer_inc = half_timer + HALF_W'(1);
  assign tick_go   = is_tick && !is_idle;
  assign expire    = tick_go && (timer_inc >= half_eff);

  // End-of-bit decisions taken in the low half.
  assign bit_inc        = bit_index + 4'd1;
  assign shift_after    = ((stage != STG_DATA_IN) && (bit_index < 4'd8)) ?
                          {shift_reg[6:0], 1'b0} : shift_reg;
  assign read_dec       = (bytes_to_read != 16'd0) ? (bytes_to_read - 16'd1) : bytes_to_read;
  assign is_write_stage = (stage == STG_ADDR_W) || (stage == STG_DATA_OUT);
  assign more_send      = (bytes_to_send != 9'd0) && (store_read_ptr < store_fill);
  assign low_same       = (bit_inc <= 4'd8);
  assign low_send       = !low_same && is_write_stage && more_send;
  assign low_rstart     = !low_same && is_write_stage && !more_send &&
                          (bytes_to_read != 16'd0);
  assign low_read       = !low_same && ((stage == STG_ADDR_R) ||
                          ((stage == STG_DATA_IN) && (read_dec != 16'd0)));
  assign low_stop       = !low_same && !low_send && !low_rstart && !low_read;

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (start_ok) begin
      phase_next = PH_START_A;
    end else if (expire) begin
      case (phase)
        PH_START_A:  phase_next = PH_START_B;
        PH_RSTART_A: phase_next = PH_RSTART_B;
        PH_START_B:  phase_next = PH_SETUP;
        PH_RSTART_B: phase_next = PH_SETUP;
        PH_SETUP:    phase_next = PH_HIGH;
        PH_HIGH:     phase_next = PH_LOW;
        PH_LOW: begin
          if (low_rstart) begin
            phase_next = PH_RSTART_A;
          end else if (low_stop) begin
            phase_next = PH_STOP_A;
          end else begin
            phase_next = PH_SETUP;
          end
        end
        PH_STOP_A:   phase_next = PH_STOP_B;
        PH_STOP_B:   phase_next = PH_IDLE;
        default:     phase_next = PH_IDLE;
      endcase
    end
  end

  // Datapath and result fields.
  always_comb begin
    stage_next          = stage;
    bit_index_next      = bit_index;
    half_timer_next     = half_timer;
    shift_reg_next      = shift_reg;
    store_fill_next     = store_fill;
    store_read_ptr_next = store_read_ptr;
    bytes_to_send_next  = bytes_to_send;
    bytes_to_read_next  = bytes_to_read;
    address_reg_next    = address_reg;
    scl_low_reg_next    = scl_low_reg;
    sda_low_reg_next    = sda_low_reg;
    rx_valid            = 1'b0;
    rx_data             = 8'h00;
    rx_final            = 1'b0;
    done                = 1'b0;
    status              = STAT_OK;

    if (is_load) begin
      if (!is_idle) begin
        status = STAT_BUSY;
      end else if (!load_ok) begin
        status = STAT_COUNT;
      end else begin
        store_fill_next = store_fill + FILL_W'(1);
      end
    end else if (is_start) begin
      if (!is_idle) begin
        status = STAT_BUSY;
      end else if (!start_ok) begin
        status = STAT_COUNT;
      end else begin
        address_reg_next    = item.target_address;
        bytes_to_send_next  = item.write_count;
        bytes_to_read_next  = item.read_count;
        store_read_ptr_next = '0;
        bit_index_next      = 4'd0;
        stage_next          = STG_ADDR_W;
        half_timer_next     = '0;
        scl_low_reg_next    = 1'b0;
        sda_low_reg_next    = 1'b0;
      end
    end else if (tick_go) begin
      half_timer_next = expire ? '0 : timer_inc;
      if (expire) begin
        case (phase)
          PH_START_A, PH_RSTART_A: begin
            sda_low_reg_next = 1'b1;
            scl_low_reg_next = 1'b0;
          end
          PH_START_B: begin
            shift_reg_next   = {address_reg, 1'b0};
            stage_next       = STG_ADDR_W;
            bit_index_next   = 4'd0;
            scl_low_reg_next = 1'b1;
            sda_low_reg_next = address_reg[6] ? 1'b0 : 1'b1;
          end
          PH_RSTART_B: begin
            shift_reg_next   = {address_reg, 1'b1};
            stage_next       = STG_ADDR_R;
            bit_index_next   = 4'd0;
            scl_low_reg_next = 1'b1;
            sda_low_reg_next = address_reg[6] ? 1'b0 : 1'b1;
          end
          PH_SETUP: begin
            scl_low_reg_next = 1'b0;
          end
          PH_HIGH: begin
            // Sample the data line just before the clock falls.
            if ((stage == STG_DATA_IN) && (bit_index < 4'd8)) begin
              shift_reg_next = {shift_reg[6:0], item.sda_in};
              if (bit_index == 4'd7) begin
                rx_valid = 1'b1;
                rx_data  = {shift_reg[6:0], item.sda_in};
                rx_final = (bytes_to_read == 16'd1);
              end
            end
            scl_low_reg_next = 1'b1;
          end
          PH_LOW: begin
            shift_reg_next = shift_after;
            bit_index_next = bit_inc;
            if (low_same) begin
              scl_low_reg_next = 1'b1;
              sda_low_reg_next = setup_sda(bit_inc, stage, shift_after, bytes_to_read);
            end else if (low_send) begin
              // Next stored byte; the store port already presents it.
              store_read_ptr_next = store_read_ptr + FILL_W'(1);
              bytes_to_send_next  = bytes_to_send - 9'd1;
              shift_reg_next      = store_rdata;
              stage_next          = STG_DATA_OUT;
              bit_index_next      = 4'd0;
              scl_low_reg_next    = 1'b1;
              sda_low_reg_next    = !store_rdata[7];
            end else if (low_rstart) begin
              scl_low_reg_next = 1'b0;
              sda_low_reg_next = 1'b0;
            end else if (low_read) begin
              bytes_to_read_next = (stage == STG_DATA_IN) ? read_dec : bytes_to_read;
              shift_reg_next     = 8'h00;
              stage_next         = STG_DATA_IN;
              bit_index_next     = 4'd0;
              scl_low_reg_next   = 1'b1;
              sda_low_reg_next   = 1'b0;
            end else begin
              bytes_to_read_next = (stage == STG_DATA_IN) ? read_dec : bytes_to_read;
              scl_low_reg_next   = 1'b1;
              sda_low_reg_next   = 1'b1;
            end
          end
          PH_STOP_A: begin
            scl_low_reg_next = 1'b0;
          end
          PH_STOP_B: begin
            // STOP done: release both lines and empty the store.
            sda_low_reg_next    = 1'b0;
            scl_low_reg_next    = 1'b0;
            store_fill_next     = '0;
            store_read_ptr_next = '0;
            bytes_to_send_next  = 9'd0;
            bytes_to_read_next  = 16'd0;
            done                = 1'b1;
          end
          default: begin
            scl_low_reg_next = 1'b0;
            sda_low_reg_next = 1'b0;
          end
        endcase
      end
    end
  end

  // Store port: write at the fill, read continuously at the read pointer.
  assign store_req.wr_en   = load_ok;
  assign store_req.wr_addr = store_fill[STORE_AW-1:0];
  assign store_req.wr_data = item.send_byte;
  assign store_req.rd_addr = store_read_ptr[STORE_AW-1:0];

  // Result of the current item.
  assign result.scl_pull_low = scl_low_reg_next;
  assign result.sda_pull_low = sda_low_reg_next;
  assign result.rx_valid     = rx_valid;
  assign result.rx_data      = rx_data;
  assign result.rx_final     = rx_final;
  assign result.busy_res     = (phase_next != PH_IDLE);
  assign result.done_res     = done;
  assign result.status       = status;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_RESET;
    end else if (cfg_wr_en) begin
      half_period <= cfg_wr_data;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stage          <= STG_ADDR_W;
      bit_index      <= 4'd0;
      half_timer     <= '0;
      shift_reg      <= 8'h00;
      store_fill     <= '0;
      store_read_ptr <= '0;
      bytes_to_send  <= 9'd0;
      bytes_to_read  <= 16'd0;
      address_reg    <= 7'd0;
      scl_low_reg    <= 1'b0;
      sda_low_reg    <= 1'b0;
    end else begin
      phase          <= phase_next;
      stage          <= stage_next;
      bit_index      <= bit_index_next;
      half_timer     <= half_timer_next;
      shift_reg      <= shift_reg_next;
      store_fill     <= store_fill_next;
      store_read_ptr <= store_read_ptr_next;
      bytes_to_send  <= bytes_to_send_next;
      bytes_to_read  <= bytes_to_read_next;
      address_reg    <= address_reg_next;
      scl_low_reg    <= scl_low_reg_next;
      sda_low_reg    <= sda_low_reg_next;
    end
  end

endmodule

// ===== rtl/i2c_master_transaction_unit.sv =====
// Channel   Dir  Handshake             Payload
// cmd       in   cmd.valid/cmd.ready   action, send_byte, target_address, write_count,
//                                      read_count, sda_in
// rsp       out  rsp.valid/rsp.ready   scl/sda pulls, rx byte, busy, done, status
// cfg       in   cfg_wr_en             cfg_wr_data: half period in ticks
//
// One command item is taken per clock while the result slot has space; its result
// is registered and appears the next cycle. The rate is set by the single result
// register, which takes a new result whenever it is empty or being read in the
// same cycle. Reset (rst, synchronous) idles the bus sequencer, releases both lines,
// empties the send store and sets the half period to five ticks. A stalled result
// holds the command channel until it is taken.
// Top level of the I2C master transaction unit.
// Depends on i2cm_pkg, the channel interfaces, i2cm_core, i2cm_ram, i2cm_rsp_reg.
`timescale 1ns / 1ps

module i2c_master_transaction_unit (
  input  logic        clk,
  input  logic        rst,
  i2cm_in_if.sink     cmd,
  i2cm_out_if.source  rsp,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import i2cm_pkg::*;

  logic       accept;
  logic       space;
  logic [7:0] store_rdata;
  store_req_t store_req;
  out_item_t  result;

  // A command transfer happens when the result slot can take its result.
  assign cmd.ready = space;
  assign accept    = cmd.valid && space;

  i2cm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (cmd.item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .store_rdata (store_rdata),
    .store_req   (store_req),
    .result      (result)
  );

  // Send store.
  i2cm_ram #(
    .WIDTH (8),
    .DEPTH (SEND_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_req.wr_en),
    .wr_addr (store_req.wr_addr),
    .wr_data (store_req.wr_data),
    .rd_addr (store_req.rd_addr),
    .rd_data (store_rdata)
  );

  i2cm_rsp_reg u_rsp (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .item_in (result),
    .take    (rsp.ready),
    .valid   (rsp.valid),
    .item    (rsp.item),
    .space   (space)
  );

  // Checks on the sequencer and the result slot.
`include "i2c_master_transaction_unit_assert.svh"

  `I2CM_ASSERT_SAME(a_stall_blocks_cmd, clk, rst, !cmd.ready, rsp.valid && !rsp.ready)
  `I2CM_ASSERT_SAME(a_done_not_busy, clk, rst, rsp.valid && rsp.item.done_res,
                    !rsp.item.busy_res && !rsp.item.scl_pull_low && !rsp.item.sda_pull_low)
  `I2CM_ASSERT_SAME(a_rx_in_transfer, clk, rst, rsp.valid && rsp.item.rx_valid,
                    rsp.item.busy_res && !rsp.item.done_res)
  `I2CM_ASSERT_NEXT(a_result_follows, clk, rst, accept, rsp.valid)

endmodule
